>>> design/lms_pkg.sv
// Shared types and constants for the lower median selector.
// Holds request and response payload structs and the sequencer state enum.
`timescale 1ns / 1ps

package lms_pkg;

   localparam int VALUE_W           = 32;
   localparam int DEFAULT_MAX_ITEMS = 64;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] median;
      logic                      overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CAND,
      ST_LATCH,
      ST_SWEEP,
      ST_DONE
   } lms_state_type;

endpackage

>>> design/lms_store.sv
// Value store: one write port, one read port, registered read data.
// Depends on lms_pkg for the value width.
`timescale 1ns / 1ps

module lms_store #(
   parameter int MaxItems = lms_pkg::DEFAULT_MAX_ITEMS,
   localparam int AW      = $clog2(MaxItems)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [lms_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [lms_pkg::VALUE_W-1:0] rd_data
);

   logic [lms_pkg::VALUE_W-1:0] mem_ff [MaxItems];
   logic [lms_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lms_ctrl.sv
// Load and rank-select sequencer for the lower median selector.
// Drives lms_store; uses lms_pkg for payload types and state enum.
`timescale 1ns / 1ps

module lms_ctrl #(
   parameter int MaxItems = lms_pkg::DEFAULT_MAX_ITEMS,
   localparam int AW      = $clog2(MaxItems),
   localparam int CNT_W   = $clog2(MaxItems + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lms_pkg::req_type            req_payload,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [lms_pkg::VALUE_W-1:0] wr_data,
   output logic [AW-1:0]               rd_addr,
   input  logic [lms_pkg::VALUE_W-1:0] rd_data,
   output logic                        res_valid,
   input  logic                        res_ready,
   output lms_pkg::rsp_type            res_payload
);

   lms_pkg::lms_state_type state_ff, state_in;

   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                              ovf_ff, ovf_in;
   logic [CNT_W-1:0]                  n_ff, n_in;
   logic [AW-1:0]                     k_ff, k_in;
   logic [AW-1:0]                     i_ff, i_in;
   logic [CNT_W-1:0]                  j_ff, j_in;
   logic [CNT_W-1:0]                  rank_ff, rank_in;
   logic                              iss_ff, iss_in;
   logic [AW-1:0]                     idx_ff, idx_in;
   logic signed [lms_pkg::VALUE_W-1:0] cand_ff, cand_in;

   logic             has_room;
   logic [CNT_W-1:0] cnt_new;
   logic             less;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lms_pkg::ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         iss_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         iss_ff   <= iss_in;
      end
      n_ff    <= n_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      rank_ff <= rank_in;
      idx_ff  <= idx_in;
      cand_ff <= cand_in;
   end

   assign has_room = cnt_ff < CNT_W'(MaxItems);
   assign cnt_new  = cnt_ff + CNT_W'(has_room);
   assign less     = ($signed(rd_data) < cand_ff) ||
                     (($signed(rd_data) == cand_ff) && (idx_ff < i_ff));

   assign wr_addr = cnt_ff[AW-1:0];
   assign wr_data = req_payload.value;

   assign res_payload.median   = cand_ff;
   assign res_payload.overflow = ovf_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      rank_in   = rank_ff;
      iss_in    = 1'b0;
      idx_in    = idx_ff;
      cand_in   = cand_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      rd_addr   = i_ff;
      res_valid = 1'b0;
      unique case (state_ff)
         lms_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (has_room) begin
                  wr_en = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               cnt_in = cnt_new;
               if (req_payload.last) begin
                  n_in     = cnt_new;
                  k_in     = AW'((cnt_new - CNT_W'(1)) >> 1);
                  i_in     = '0;
                  state_in = lms_pkg::ST_CAND;
               end
            end
         end
         lms_pkg::ST_CAND: begin
            rd_addr  = i_ff;
            state_in = lms_pkg::ST_LATCH;
         end
         lms_pkg::ST_LATCH: begin
            cand_in  = $signed(rd_data);
            j_in     = '0;
            rank_in  = '0;
            state_in = lms_pkg::ST_SWEEP;
         end
         lms_pkg::ST_SWEEP: begin
            if (j_ff < n_ff) begin
               rd_addr = j_ff[AW-1:0];
               iss_in  = 1'b1;
               idx_in  = j_ff[AW-1:0];
               j_in    = j_ff + CNT_W'(1);
            end
            if (iss_ff && less) begin
               rank_in = rank_ff + CNT_W'(1);
            end
            if ((j_ff == n_ff) && !iss_ff) begin
               if (rank_ff == CNT_W'(k_ff)) begin
                  state_in = lms_pkg::ST_DONE;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = lms_pkg::ST_CAND;
               end
            end
         end
         lms_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = lms_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = lms_pkg::ST_LOAD;
         end
      endcase
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MaxItems))
      else $error("item count above store depth");

   a_cand_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lms_pkg::ST_LOAD) |-> (CNT_W'(i_ff) < n_ff && CNT_W'(k_ff) < n_ff))
      else $error("candidate or target rank outside list");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lms_pkg::ST_SWEEP) |-> (j_ff <= n_ff && rank_ff <= n_ff))
      else $error("sweep index or rank past list length");

   a_done_rank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lms_pkg::ST_SWEEP && state_in == lms_pkg::ST_DONE)
      |-> (rank_ff == CNT_W'(k_ff)))
      else $error("result taken with wrong rank");

endmodule

>>> design/lower_median_select.sv
// Top level of the lower median selector: request/response handshakes.
// Instantiates lms_ctrl and lms_store; uses lms_pkg payload types.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   lms_pkg::req_type (value, last)
//   rsp_      out        rsp_valid / rsp_ready   lms_pkg::rsp_type (median, overflow)
//
// Loading takes one request per cycle through the store write port.
// After the last request, each candidate is ranked by a sweep of the single
// store read port.
// Reset clears the count, overflow flag, sequencer state and response valid.
// A pending response holds the sequencer in its done state; loading of the
// next list waits until the response slot frees.
`timescale 1ns / 1ps

module lower_median_select #(
   parameter int MaxItems = lms_pkg::DEFAULT_MAX_ITEMS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lms_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lms_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(MaxItems);

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [lms_pkg::VALUE_W-1:0] wr_data;
   logic [AW-1:0]               rd_addr;
   logic [lms_pkg::VALUE_W-1:0] rd_data;
   logic                        res_valid;
   logic                        res_ready;
   lms_pkg::rsp_type            res_payload;

   logic             rsp_valid_ff, rsp_valid_in;
   lms_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   lms_ctrl #(.MaxItems(MaxItems)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload)
   );

   lms_store #(.MaxItems(MaxItems)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
